// ----- sv/utf8_stream_decoder_macros.svh -----
// assertion macros shared by the utf8 decoder modules
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// plain invariant, checked on every clock outside reset
`define UTF8D_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define UTF8D_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/utf8d_pkg.sv -----
// shared types, constants and helpers of the utf8 stream decoder
`default_nettype none

package utf8d_pkg;

  localparam int CP_W       = 31;
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_AW     = $clog2(CMD_DEPTH);
  localparam int CMD_CW     = CMD_AW + 1;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 31'h0000FFFD;
  localparam logic [CP_W-1:0] NULL_ALIAS_CP  = 31'h0000ED00;

  // command for the back end: sub_count substitutions, then an optional value
  typedef struct packed {
    logic [2:0]      sub_count;
    logic            has_val;
    logic [CP_W-1:0] code_point;
    logic            overlong;
  } cmd_t;

  // smallest value that really needs a sequence of this length
  function automatic logic [CP_W-1:0] seq_limit(input logic [2:0] seq_len);
    logic [CP_W-1:0] lim;
    case (seq_len)
      3'd2:    lim = 31'h00000080;
      3'd3:    lim = 31'h00000800;
      3'd4:    lim = 31'h00010000;
      3'd5:    lim = 31'h00200000;
      default: lim = 31'h04000000;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// ----- sv/utf8_stream_decoder.sv -----
// path: results pass the command queue, working registers and the output register
// throughput: one byte per cycle while each byte gives at most one result and the
//   output is popped; the output register emits at most one result per cycle and a
//   four-request queue lets the front keep taking bytes while a byte's results drain
// reset: synchronous active-low rst_n clears the open sequence, queue, output and
//   sets null_remap_enable to 0
`default_nettype none

module utf8_stream_decoder
  import utf8d_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  output logic                 in_full,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_end_of_string,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [CP_W-1:0]      out_code_point,
  output logic                 out_overlong_form,
  output logic                 out_substituted,
  output logic                 out_run_end,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_null_remap_enable
);

  logic remap_r;
  logic accept;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_full;
  assign accept    = in_push && !cmd_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      remap_r <= cfg_null_remap_enable;
    end
  end

  utf8d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_string (in_end_of_string),
    .remap_en      (remap_r),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  utf8d_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  utf8d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd_out),
    .cmd_empty         (cmd_empty),
    .cmd_pop           (cmd_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_code_point    (out_code_point),
    .out_overlong_form (out_overlong_form),
    .out_substituted   (out_substituted),
    .out_run_end       (out_run_end)
  );

endmodule

`default_nettype wire

// ----- sv/utf8d_cmd_fifo.sv -----
// small register queue between the decoder front and the result back end
`default_nettype none

module utf8d_cmd_fifo
  import utf8d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  cmd_t              mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CW-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == CMD_CW'(CMD_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/utf8d_front.sv -----
// decoder front: holds the open sequence and turns each byte into a result order
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8d_front
  import utf8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_string,
  input  wire logic       remap_en,
  output logic            cmd_push,
  output cmd_t            cmd
);

  logic [2:0]      held_r, held_nxt;
  logic [2:0]      len_r, len_nxt;
  logic [CP_W-1:0] pv_r, pv_nxt;

  logic            is_cont, extend;
  logic [2:0]      held_inc, held_sub;
  logic [CP_W-1:0] pv_ext;
  logic [2:0]      lead_len;
  logic [CP_W-1:0] lead_val;

  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign extend   = (held_r != 3'd0) && (held_r < len_r) && is_cont;
  assign held_inc = held_r + 3'd1;
  assign pv_ext   = {pv_r[CP_W-7:0], data_byte[5:0]};
  assign held_sub = (held_r == 3'd7) ? 3'd6 : held_r;

  // lead byte length and payload bits
  always_comb begin
    lead_len = 3'd0;
    lead_val = '0;
    if (data_byte[7:5] == 3'b110) begin
      lead_len = 3'd2;
      lead_val = CP_W'(data_byte[4:0]);
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_len = 3'd3;
      lead_val = CP_W'(data_byte[3:0]);
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_len = 3'd4;
      lead_val = CP_W'(data_byte[2:0]);
    end else if (data_byte[7:2] == 6'b111110) begin
      lead_len = 3'd5;
      lead_val = CP_W'(data_byte[1:0]);
    end else if (data_byte[7:1] == 7'b1111110) begin
      lead_len = 3'd6;
      lead_val = CP_W'(data_byte[0]);
    end
  end

  always_comb begin
    held_nxt       = held_r;
    len_nxt        = len_r;
    pv_nxt         = pv_r;
    cmd.sub_count  = 3'd0;
    cmd.has_val    = 1'b0;
    cmd.code_point = '0;
    cmd.overlong   = 1'b0;
    if (extend) begin
      if (held_inc >= len_r) begin
        cmd.has_val    = 1'b1;
        cmd.overlong   = (pv_ext < seq_limit(len_r));
        cmd.code_point = (len_r == 3'd3 && pv_ext == NULL_ALIAS_CP && remap_en) ? '0 : pv_ext;
        held_nxt       = 3'd0;
        len_nxt        = 3'd0;
        pv_nxt         = '0;
      end else if (end_of_string) begin
        cmd.sub_count = held_inc;
        held_nxt      = 3'd0;
        len_nxt       = 3'd0;
        pv_nxt        = '0;
      end else begin
        held_nxt = held_inc;
        pv_nxt   = pv_ext;
      end
    end else begin
      // a broken sequence is flushed first, then the byte starts fresh
      cmd.sub_count = held_sub;
      held_nxt      = 3'd0;
      len_nxt       = 3'd0;
      pv_nxt        = '0;
      if (!data_byte[7]) begin
        cmd.has_val    = 1'b1;
        cmd.code_point = CP_W'(data_byte);
      end else if (lead_len != 3'd0 && !end_of_string) begin
        held_nxt = 3'd1;
        len_nxt  = lead_len;
        pv_nxt   = lead_val;
      end else begin
        cmd.sub_count = held_sub + 3'd1;
      end
    end
  end

  assign cmd_push = accept && (cmd.sub_count != 3'd0 || cmd.has_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 3'd0;
      len_r  <= 3'd0;
      pv_r   <= '0;
    end else if (accept) begin
      held_r <= held_nxt;
      len_r  <= len_nxt;
      pv_r   <= pv_nxt;
    end
  end

  `UTF8D_ASSERT_IMPLY(a_held_below_len, held_r != 3'd0, held_r < len_r && len_r <= 3'd6,
                      "open sequence count out of range")
  `UTF8D_ASSERT_IMPLY(a_idle_clean, held_r == 3'd0, len_r == 3'd0 && pv_r == '0,
                      "idle decoder keeps stale sequence state")
  `UTF8D_ASSERT_NEXT(a_eos_closes, accept && end_of_string, held_r == 3'd0,
                     "sequence left open after end of string")

endmodule

`default_nettype wire

// ----- sv/utf8d_back.sv -----
// decoder back end: expands result orders into single results behind an output register
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8d_back
  import utf8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic        cmd_empty,
  output logic             cmd_pop,
  input  wire logic        out_pop,
  output logic             out_empty,
  output logic [CP_W-1:0]  out_code_point,
  output logic             out_overlong_form,
  output logic             out_substituted,
  output logic             out_run_end
);

  logic            busy_r, busy_nxt;
  logic [2:0]      sub_left_r, sub_left_nxt;
  logic            has_val_r, has_val_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic            ovl_r, ovl_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] out_cp_r, out_cp_nxt;
  logic            out_ovl_r, out_ovl_nxt;
  logic            out_sub_r, out_sub_nxt;
  logic            out_end_r, out_end_nxt;

  logic slot_free, emit, last, load;

  assign slot_free = !out_valid_r || out_pop;
  assign emit      = busy_r && slot_free;
  assign last      = (sub_left_r == 3'd0) || (sub_left_r == 3'd1 && !has_val_r);
  assign load      = !busy_r || (emit && last);
  assign cmd_pop   = load && !cmd_empty;

  always_comb begin
    busy_nxt      = busy_r;
    sub_left_nxt  = sub_left_r;
    has_val_nxt   = has_val_r;
    cp_nxt        = cp_r;
    ovl_nxt       = ovl_r;
    out_valid_nxt = out_valid_r;
    out_cp_nxt    = out_cp_r;
    out_ovl_nxt   = out_ovl_r;
    out_sub_nxt   = out_sub_r;
    out_end_nxt   = out_end_r;

    if (slot_free) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_end_nxt   = last;
      if (sub_left_r != 3'd0) begin
        out_cp_nxt   = REPLACEMENT_CP;
        out_ovl_nxt  = 1'b0;
        out_sub_nxt  = 1'b1;
        sub_left_nxt = sub_left_r - 3'd1;
      end else begin
        out_cp_nxt  = cp_r;
        out_ovl_nxt = ovl_r;
        out_sub_nxt = 1'b0;
        has_val_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = !cmd_empty;
      if (!cmd_empty) begin
        sub_left_nxt = cmd.sub_count;
        has_val_nxt  = cmd.has_val;
        cp_nxt       = cmd.code_point;
        ovl_nxt      = cmd.overlong;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sub_left_r <= sub_left_nxt;
    has_val_r  <= has_val_nxt;
    cp_r       <= cp_nxt;
    ovl_r      <= ovl_nxt;
    out_cp_r   <= out_cp_nxt;
    out_ovl_r  <= out_ovl_nxt;
    out_sub_r  <= out_sub_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_empty         = !out_valid_r;
  assign out_code_point    = out_cp_r;
  assign out_overlong_form = out_ovl_r;
  assign out_substituted   = out_sub_r;
  assign out_run_end       = out_end_r;

  `UTF8D_ASSERT_IMPLY(a_busy_has_work, busy_r, sub_left_r != 3'd0 || has_val_r,
                      "working request has nothing left to emit")
  `UTF8D_ASSERT_IMPLY(a_sub_is_fffd, out_valid_r && out_sub_r,
                      out_cp_r == REPLACEMENT_CP && !out_ovl_r,
                      "substituted result with wrong payload")
  `UTF8D_ASSERT_IMPLY(a_sub_bound, busy_r, sub_left_r <= 3'd6,
                      "too many substitutions queued for one byte")

endmodule

`default_nettype wire

// ----- sim/utf8_stream_decoder_tb.sv -----
// testbench of the utf8 stream decoder: directed and random byte streams against a predictor
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;
  import utf8d_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [CP_W-1:0] code_point;
    logic            overlong;
    logic            subst;
    logic            run_end;
  } cp_result_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_push = 1'b0;
  logic            in_full;
  logic [7:0]      in_data_byte = 8'h00;
  logic            in_end_of_string = 1'b0;
  logic            out_empty;
  logic            out_pop = 1'b0;
  logic [CP_W-1:0] out_code_point;
  logic            out_overlong_form;
  logic            out_substituted;
  logic            out_run_end;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic            cfg_null_remap_enable = 1'b0;

  // decoder state as predicted
  logic [2:0]      held_cnt = '0;
  logic [2:0]      open_len = '0;
  logic [CP_W-1:0] acc_val = '0;
  logic            remap_en = 1'b0;

  cp_result_t expected_cp_q[$];
  cp_result_t byte_cp_q[$];

  bit in_no_idle  = 1'b0;
  bit out_no_idle = 1'b0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int subst_seen   = 0;
  int overlong_seen = 0;
  int err_cnt      = 0;

  utf8_stream_decoder u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_data_byte          (in_data_byte),
    .in_end_of_string      (in_end_of_string),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_code_point        (out_code_point),
    .out_overlong_form     (out_overlong_form),
    .out_substituted       (out_substituted),
    .out_run_end           (out_run_end),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_null_remap_enable (cfg_null_remap_enable)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function int draw_wait(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  function bit draw_eos();
    return ($urandom_range(0, 15) == 0);
  endfunction

  function void add_cp(logic [CP_W-1:0] cp, logic ovl, logic sub);
    cp_result_t r;
    r.code_point = cp;
    r.overlong   = ovl;
    r.subst      = sub;
    r.run_end    = 1'b0;
    byte_cp_q.push_back(r);
  endfunction

  // one replacement per byte still held
  function void drop_held();
    for (int k = 0; k < held_cnt; k++) add_cp(REPLACEMENT_CP, 1'b0, 1'b1);
    held_cnt = '0;
    open_len = '0;
    acc_val  = '0;
  endfunction

  function void close_seq();
    logic [CP_W-1:0] floor_val;
    logic [CP_W-1:0] cp;
    case (open_len)
      3'd2:    floor_val = 31'h00000080;
      3'd3:    floor_val = 31'h00000800;
      3'd4:    floor_val = 31'h00010000;
      3'd5:    floor_val = 31'h00200000;
      default: floor_val = 31'h04000000;
    endcase
    cp = acc_val;
    if (open_len == 3'd3 && acc_val == NULL_ALIAS_CP && remap_en) cp = '0;
    add_cp(cp, acc_val < floor_val, 1'b0);
    held_cnt = '0;
    open_len = '0;
    acc_val  = '0;
  endfunction

  function void start_byte(logic [7:0] b);
    casez (b)
      8'b0???????: add_cp({23'b0, b}, 1'b0, 1'b0);
      8'b110?????: begin
        held_cnt = 3'd1; open_len = 3'd2; acc_val = {26'b0, b[4:0]};
      end
      8'b1110????: begin
        held_cnt = 3'd1; open_len = 3'd3; acc_val = {27'b0, b[3:0]};
      end
      8'b11110???: begin
        held_cnt = 3'd1; open_len = 3'd4; acc_val = {28'b0, b[2:0]};
      end
      8'b111110??: begin
        held_cnt = 3'd1; open_len = 3'd5; acc_val = {29'b0, b[1:0]};
      end
      8'b1111110?: begin
        held_cnt = 3'd1; open_len = 3'd6; acc_val = {30'b0, b[0]};
      end
      // stray continuation, 0xfe and 0xff
      default: add_cp(REPLACEMENT_CP, 1'b0, 1'b1);
    endcase
  endfunction

  function void decode_byte(logic [7:0] b, logic eos);
    byte_cp_q.delete();
    if (held_cnt != 0 && held_cnt < open_len && b[7:6] == 2'b10) begin
      acc_val  = {acc_val[CP_W-7:0], b[5:0]};
      held_cnt = held_cnt + 3'd1;
      if (held_cnt >= open_len) close_seq();
    end else begin
      if (held_cnt != 0) drop_held();
      start_byte(b);
    end
    if (eos && held_cnt != 0) drop_held();
    if (byte_cp_q.size() > 0) byte_cp_q[byte_cp_q.size()-1].run_end = 1'b1;
    foreach (byte_cp_q[i]) expected_cp_q.push_back(byte_cp_q[i]);
  endfunction

  // push stays high after the request so back-to-back bytes need no toggle
  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    gap = draw_wait(in_no_idle);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push          <= 1'b1;
    in_data_byte     <= b;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_full);
    decode_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic settle_idle();
    in_push <= 1'b0;
    while (expected_cp_q.size() != 0) @(posedge clk);
    // a byte that only extends a sequence may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_remap(logic v);
    settle_idle();
    cfg_valid             <= 1'b1;
    cfg_null_remap_enable <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    remap_en = v;
  endtask

  task automatic test_ascii_and_invalid();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    // broken sequence, the letter is decoded after the replacement
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    // string ends with two bytes held
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b1);
  endtask

  task automatic test_sequence_lengths();
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // largest six-byte value
    send_byte(8'hFD, 1'b0);
    repeat (4) send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_null_remap();
    write_remap(1'b1);
    send_byte(8'hEE, 1'b0);
    send_byte(8'hB4, 1'b0);
    send_byte(8'h80, 1'b0);
    // same value as an overlong four-byte form is not remapped
    send_byte(8'hF0, 1'b0);
    send_byte(8'h8E, 1'b0);
    send_byte(8'hB4, 1'b0);
    send_byte(8'h80, 1'b1);
    write_remap(1'b0);
  endtask

  task automatic send_random_seq();
    int kind;
    int len;
    int cut;
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) in_no_idle = ~in_no_idle;
    if ($urandom_range(0, 7) == 0) out_no_idle = ~out_no_idle;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      send_byte(8'($urandom_range(0, 255)), draw_eos());
    end else if (kind < 15) begin
      send_byte(8'hEE, 1'b0);
      send_byte(8'hB4, 1'b0);
      send_byte(8'h80, draw_eos());
    end else begin
      len = $urandom_range(1, 6);
      cut = (kind < 27 && len > 1) ? $urandom_range(1, len - 1) : len;
      case (len)
        1:       b = 8'($urandom_range(0, 127));
        2:       b = 8'hC0 | 8'($urandom_range(0, 31));
        3:       b = 8'hE0 | 8'($urandom_range(0, 15));
        4:       b = 8'hF0 | 8'($urandom_range(0, 7));
        5:       b = 8'hF8 | 8'($urandom_range(0, 3));
        default: b = 8'hFC | 8'($urandom_range(0, 1));
      endcase
      send_byte(b, draw_eos());
      for (int i = 1; i < len; i++) begin
        if (i == cut) begin
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          send_byte(b, draw_eos());
          break;
        end
        send_byte(8'h80 | 8'($urandom_range(0, 63)), draw_eos());
      end
    end
  endtask

  task automatic test_random_traffic(int n);
    int stop_at;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) send_random_seq();
    send_byte(8'h2E, 1'b1);
    in_no_idle  = 1'b0;
    out_no_idle = 1'b0;
  endtask

  // result side: random pop stalls, compare against the oldest expectation
  initial begin
    int stall;
    cp_result_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        results_seen++;
        if (out_substituted) subst_seen++;
        if (out_overlong_form) overlong_seen++;
        if (expected_cp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none actual code_point %h", $time,
                   out_code_point);
        end else begin
          want = expected_cp_q.pop_front();
          if (out_code_point !== want.code_point) begin
            err_cnt++;
            $display("%0t: code_point expected %h actual %h", $time, want.code_point,
                     out_code_point);
          end
          if (out_overlong_form !== want.overlong) begin
            err_cnt++;
            $display("%0t: overlong_form expected %b actual %b", $time, want.overlong,
                     out_overlong_form);
          end
          if (out_substituted !== want.subst) begin
            err_cnt++;
            $display("%0t: substituted expected %b actual %b", $time, want.subst,
                     out_substituted);
          end
          if (out_run_end !== want.run_end) begin
            err_cnt++;
            $display("%0t: run_end expected %b actual %b", $time, want.run_end, out_run_end);
          end
        end
        stall = draw_wait(out_no_idle);
      end else if (stall > 0) begin
        stall--;
      end
      out_pop <= (stall == 0);
    end
  end

  // watchdog on cycles with no request moving anywhere
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle_cnt = 0;
      else
        idle_cnt++;
    end
    $display("%0t: timeout, %0d results still expected", $time, expected_cp_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_ascii_and_invalid();
    test_sequence_lengths();
    test_null_remap();
    test_random_traffic(70);
    write_remap(1'b1);
    test_random_traffic(70);
    write_remap(1'b0);
    test_random_traffic(55);
    settle_idle();
    $display("decoded %0d bytes into %0d code points, %0d replacements, %0d overlong",
             bytes_sent, results_seen, subst_seen, overlong_seen);
    $display("null remap toggled off and on across random streams, %0d mismatches", err_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- utf8_stream_decoder.f -----
+incdir+sv
sv/utf8d_pkg.sv
sv/utf8d_cmd_fifo.sv
sv/utf8d_front.sv
sv/utf8d_back.sv
sv/utf8_stream_decoder.sv
sim/utf8_stream_decoder_tb.sv
